>>> rtl/core/llrb_pkg.sv
package llrb_pkg;

  localparam int unsigned STORE_BYTES  = 8192;
  localparam int unsigned READER_SLOTS = 8;
  localparam int unsigned MAX_LINE     = 64;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned SLOT_W = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int unsigned LINE_W = $clog2(MAX_LINE + 1);
  localparam int unsigned CNT_W  = 32;

  localparam logic [7:0] BYTE_NL  = 8'h0A;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_OVERRUN  = 3'd1,
    ST_NONE     = 3'd2,
    ST_BAD_SLOT = 3'd3,
    ST_ACK      = 3'd4
  } status_e;

  // store read address source
  typedef enum logic [1:0] {
    RA_OLDEST,
    RA_OLDEST_NEXT,
    RA_POS,
    RA_CUR_NEXT
  } rd_addr_e;

  // result byte source
  typedef enum logic [1:0] {
    OB_ZERO,
    OB_NL,
    OB_DATA
  } out_byte_e;

  typedef struct packed {
    logic      latch;
    logic      push;
    logic      ovf_update;
    logic      ovf_clear;
    logic      pop;
    logic      mem_rd;
    rd_addr_e  rd_sel;
    logic      open_slot;
    logic      close_slot;
    logic      pos_to_oldest;
    logic      pos_wr;
    logic      pos_step;
    logic      cur_load;
    logic      cur_step;
    logic      emit;
    out_byte_e byte_sel;
    status_e   status;
    logic      last;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  write_last;
    logic  ovf_next;
    logic  slot_ok;
    logic  slot_open;
    logic  overrun;
    logic  pos_at_end;
    logic  rd_term;
    logic  line_full;
    logic  cur_last;
    logic  evict_last;
  } stat_t;

  function automatic addr_t addr_inc(addr_t a);
    return (a == addr_t'(STORE_BYTES - 1)) ? '0 : a + addr_t'(1);
  endfunction

endpackage

>>> rtl/core/llrb_ctrl.sv
module llrb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  llrb_pkg::stat_t stat_i,
  output llrb_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EV_START,
    S_EV_CHK,
    S_RD_CHK,
    S_APPEND
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.byte_sel = llrb_pkg::OB_ZERO;
          cmd_o.status   = llrb_pkg::ST_ACK;
          state_d        = S_IDLE;
          if (stat_i.mode == llrb_pkg::MODE_WRITE) begin
            cmd_o.push = 1'b1;
            if (stat_i.write_last) begin
              cmd_o.ovf_clear = 1'b1;
              if (stat_i.ovf_next) begin
                state_d = S_EV_START;
              end
            end else begin
              cmd_o.ovf_update = 1'b1;
            end
          end else if (!stat_i.slot_ok) begin
            cmd_o.status = llrb_pkg::ST_BAD_SLOT;
          end else begin
            case (stat_i.mode)
              llrb_pkg::MODE_OPEN: begin
                if (stat_i.slot_open) begin
                  cmd_o.status = llrb_pkg::ST_BAD_SLOT;
                end else begin
                  cmd_o.open_slot     = 1'b1;
                  cmd_o.pos_to_oldest = 1'b1;
                end
              end
              llrb_pkg::MODE_CLOSE: begin
                cmd_o.close_slot = 1'b1;
              end
              llrb_pkg::MODE_READ: begin
                if (!stat_i.slot_open) begin
                  cmd_o.status = llrb_pkg::ST_BAD_SLOT;
                end else if (stat_i.overrun) begin
                  cmd_o.pos_to_oldest = 1'b1;
                  cmd_o.status        = llrb_pkg::ST_OVERRUN;
                end else if (stat_i.pos_at_end) begin
                  cmd_o.status = llrb_pkg::ST_NONE;
                end else begin
                  // line read starts: first byte fetched, no result yet
                  cmd_o.emit     = 1'b0;
                  cmd_o.cur_load = 1'b1;
                  cmd_o.mem_rd   = 1'b1;
                  cmd_o.rd_sel   = llrb_pkg::RA_POS;
                  state_d        = S_RD_CHK;
                end
              end
              default: begin
                cmd_o.status = llrb_pkg::ST_BAD_SLOT;
              end
            endcase
          end
        end
      end
      S_EV_START: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = llrb_pkg::RA_OLDEST;
        state_d      = S_EV_CHK;
      end
      S_EV_CHK: begin
        cmd_o.pop = 1'b1;
        if (stat_i.rd_term || stat_i.evict_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = llrb_pkg::RA_OLDEST_NEXT;
        end
      end
      S_RD_CHK: begin
        if (out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = llrb_pkg::ST_DATA;
          if (stat_i.rd_term) begin
            cmd_o.byte_sel = llrb_pkg::OB_NL;
            cmd_o.last     = 1'b1;
            cmd_o.pos_wr   = 1'b1;
            cmd_o.pos_step = 1'b1;
            state_d        = S_IDLE;
          end else if (stat_i.line_full) begin
            // line cut: last byte becomes newline and is read again later
            cmd_o.byte_sel = llrb_pkg::OB_NL;
            cmd_o.last     = 1'b1;
            cmd_o.pos_wr   = 1'b1;
            state_d        = S_IDLE;
          end else if (stat_i.cur_last) begin
            cmd_o.byte_sel = llrb_pkg::OB_DATA;
            cmd_o.pos_wr   = 1'b1;
            cmd_o.pos_step = 1'b1;
            state_d        = S_APPEND;
          end else begin
            cmd_o.byte_sel = llrb_pkg::OB_DATA;
            cmd_o.cur_step = 1'b1;
            cmd_o.mem_rd   = 1'b1;
            cmd_o.rd_sel   = llrb_pkg::RA_CUR_NEXT;
          end
        end
      end
      S_APPEND: begin
        if (out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.byte_sel = llrb_pkg::OB_NL;
          cmd_o.status   = llrb_pkg::ST_DATA;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/llrb_datapath.sv
module llrb_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      data_byte_i,
  input  logic [15:0]     write_length_i,
  input  logic            write_first_i,
  input  logic            write_last_i,
  input  logic [2:0]      reader_slot_i,
  input  logic [6:0]      read_max_i,
  input  llrb_pkg::cmd_t  cmd_i,
  output llrb_pkg::stat_t stat_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            last_o
);

  // latched item
  llrb_pkg::mode_e                mode_q;
  logic [7:0]                     data_q;
  logic [15:0]                    len_q;
  logic                           first_q;
  logic                           lastw_q;
  logic [2:0]                     slot_q;
  logic [llrb_pkg::LINE_W-1:0]    rmax_q;
  logic [llrb_pkg::LINE_W-1:0]    rmax_clamped;

  // ring counters with their wrapped store addresses
  llrb_pkg::cnt_t                 oldest_q, newest_q;
  llrb_pkg::addr_t                oldest_addr_q, newest_addr_q;
  logic                           ovf_q;

  llrb_pkg::cnt_t                 pos_q      [llrb_pkg::READER_SLOTS];
  llrb_pkg::addr_t                pos_addr_q [llrb_pkg::READER_SLOTS];
  logic [llrb_pkg::READER_SLOTS-1:0] open_q;

  // line read cursor
  llrb_pkg::cnt_t                 cur_q;
  llrb_pkg::addr_t                cur_addr_q;
  logic [llrb_pkg::LINE_W-1:0]    n_q;

  logic [7:0]                     mem [llrb_pkg::STORE_BYTES];
  logic [7:0]                     rdata_q;
  llrb_pkg::addr_t                rd_addr;

  logic [7:0]                     out_byte_q;
  logic [2:0]                     status_q;
  logic                           last_q;
  logic [7:0]                     byte_next;

  logic [llrb_pkg::SLOT_W-1:0]    slot_idx;
  llrb_pkg::cnt_t                 used;
  logic                           drop;
  logic                           ovf_cmp;
  llrb_pkg::cnt_t                 pos_sel;
  llrb_pkg::addr_t                pos_addr_sel;
  llrb_pkg::cnt_t                 pos_diff;

  assign slot_idx     = llrb_pkg::SLOT_W'(slot_q);
  assign pos_sel      = pos_q[slot_idx];
  assign pos_addr_sel = pos_addr_q[slot_idx];
  assign used         = newest_q - oldest_q;
  assign drop         = (used >= llrb_pkg::CNT_W'(llrb_pkg::STORE_BYTES - 1));
  assign ovf_cmp      = ({1'b0, used} + 33'(len_q)) >= 33'(llrb_pkg::STORE_BYTES);
  assign pos_diff     = pos_sel - oldest_q;

  always_comb begin
    if (read_max_i == 7'd0) begin
      rmax_clamped = llrb_pkg::LINE_W'(1);
    end else if (read_max_i > 7'(llrb_pkg::MAX_LINE)) begin
      rmax_clamped = llrb_pkg::LINE_W'(llrb_pkg::MAX_LINE);
    end else begin
      rmax_clamped = llrb_pkg::LINE_W'(read_max_i);
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.write_last  = lastw_q;
    stat_o.ovf_next    = first_q ? ovf_cmp : ovf_q;
    stat_o.slot_ok     = (32'(slot_q) < 32'(llrb_pkg::READER_SLOTS));
    stat_o.slot_open   = open_q[slot_idx];
    stat_o.overrun     = pos_diff[llrb_pkg::CNT_W-1];
    stat_o.pos_at_end  = (pos_sel == newest_q);
    stat_o.rd_term     = (rdata_q == llrb_pkg::BYTE_NL) || (rdata_q == llrb_pkg::BYTE_NUL);
    stat_o.line_full   = ((n_q + llrb_pkg::LINE_W'(1)) == rmax_q);
    stat_o.cur_last    = ((cur_q + llrb_pkg::CNT_W'(1)) == newest_q);
    stat_o.evict_last  = ((oldest_q + llrb_pkg::CNT_W'(1)) == newest_q);
  end

  always_comb begin
    case (cmd_i.rd_sel)
      llrb_pkg::RA_OLDEST:      rd_addr = oldest_addr_q;
      llrb_pkg::RA_OLDEST_NEXT: rd_addr = llrb_pkg::addr_inc(oldest_addr_q);
      llrb_pkg::RA_POS:         rd_addr = pos_addr_sel;
      llrb_pkg::RA_CUR_NEXT:    rd_addr = llrb_pkg::addr_inc(cur_addr_q);
      default:                  rd_addr = oldest_addr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.byte_sel)
      llrb_pkg::OB_NL:   byte_next = llrb_pkg::BYTE_NL;
      llrb_pkg::OB_DATA: byte_next = rdata_q;
      default:           byte_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= llrb_pkg::mode_e'(mode_i);
      data_q  <= data_byte_i;
      len_q   <= write_length_i;
      first_q <= write_first_i;
      lastw_q <= write_last_i;
      slot_q  <= reader_slot_i;
      rmax_q  <= rmax_clamped;
    end
    if (cmd_i.emit) begin
      out_byte_q <= byte_next;
      status_q   <= cmd_i.status;
      last_q     <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[newest_addr_q] <= data_q;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q      <= '0;
      oldest_addr_q <= '0;
      newest_q      <= '0;
      newest_addr_q <= '0;
      ovf_q         <= 1'b0;
      open_q        <= '0;
      cur_q         <= '0;
      cur_addr_q    <= '0;
      n_q           <= '0;
      for (int i = 0; i < llrb_pkg::READER_SLOTS; i++) begin
        pos_q[i]      <= '0;
        pos_addr_q[i] <= '0;
      end
    end else begin
      if (cmd_i.push) begin
        newest_q      <= newest_q + llrb_pkg::CNT_W'(1);
        newest_addr_q <= llrb_pkg::addr_inc(newest_addr_q);
      end
      // store full after the push drops the oldest byte
      if ((cmd_i.push && drop) || cmd_i.pop) begin
        oldest_q      <= oldest_q + llrb_pkg::CNT_W'(1);
        oldest_addr_q <= llrb_pkg::addr_inc(oldest_addr_q);
      end
      if (cmd_i.ovf_clear) begin
        ovf_q <= 1'b0;
      end else if (cmd_i.ovf_update) begin
        ovf_q <= stat_o.ovf_next;
      end
      if (cmd_i.open_slot) begin
        open_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.close_slot) begin
        open_q[slot_idx] <= 1'b0;
      end
      if (cmd_i.pos_to_oldest) begin
        pos_q[slot_idx]      <= oldest_q;
        pos_addr_q[slot_idx] <= oldest_addr_q;
      end else if (cmd_i.pos_wr) begin
        if (cmd_i.pos_step) begin
          pos_q[slot_idx]      <= cur_q + llrb_pkg::CNT_W'(1);
          pos_addr_q[slot_idx] <= llrb_pkg::addr_inc(cur_addr_q);
        end else begin
          pos_q[slot_idx]      <= cur_q;
          pos_addr_q[slot_idx] <= cur_addr_q;
        end
      end
      if (cmd_i.cur_load) begin
        cur_q      <= pos_sel;
        cur_addr_q <= pos_addr_sel;
        n_q        <= '0;
      end else if (cmd_i.cur_step) begin
        cur_q      <= cur_q + llrb_pkg::CNT_W'(1);
        cur_addr_q <= llrb_pkg::addr_inc(cur_addr_q);
        n_q        <= n_q + llrb_pkg::LINE_W'(1);
      end
    end
  end

  assign out_byte_o = out_byte_q;
  assign status_o   = status_q;
  assign last_o     = last_q;

endmodule

>>> rtl/core/line_log_ring_buffer.sv
// byte log ring buffer with line readers
// input channel (in_valid_i / in_ready_o) carries one command per transaction:
//   write byte, open reader, close reader or read line, selected by mode_i.
// output channel (out_valid_o / out_ready_i) returns result transactions;
//   last_o marks the final result of a command.
// every command except a line read gives exactly one result.
// a command is latched while idle and executed in the next state once the
//   output side can take its result.
// a write ending an overflowing message then evicts the oldest line, one store
//   byte per cycle after a start state, before the next command is taken.
// a line read fetches the first byte before any result, then returns the line
//   byte by byte, and appends a newline in its own state when the data ends
//   without one; eviction and line reads share the single store read port.
// reset empties the log and closes all reader slots; no clearing pass.
// a stalled receiver holds the current result and stops the command in
//   progress until the result is taken; a new command is taken only when
//   the previous one has produced all its results.
module line_log_ring_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] write_length_i,
  input  logic        write_first_i,
  input  logic        write_last_i,
  input  logic [2:0]  reader_slot_i,
  input  logic [6:0]  read_max_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  llrb_pkg::cmd_t  cmd;
  llrb_pkg::stat_t stat;

  llrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  llrb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .write_length_i (write_length_i),
    .write_first_i  (write_first_i),
    .write_last_i   (write_last_i),
    .reader_slot_i  (reader_slot_i),
    .read_max_i     (read_max_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

>>> rtl/core/llrb_checker.sv
module llrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  mode_i,
  input logic [7:0]  data_byte_i,
  input logic [15:0] write_length_i,
  input logic        write_first_i,
  input logic        write_last_i,
  input logic [2:0]  reader_slot_i,
  input logic [6:0]  read_max_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  status_o,
  input logic        last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // ready drops after a command is taken, so commands are never taken back to back
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken back to back");

  // any status other than data ends the command and carries a zero byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != llrb_pkg::ST_DATA) |-> last_o && (out_byte_o == 8'h00))
    else $error("non-data result not final or byte not zero");

  // every returned line ends in a newline
  a_line_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && (status_o == llrb_pkg::ST_DATA) |->
      out_byte_o == llrb_pkg::BYTE_NL)
    else $error("line does not end in newline");

endmodule

bind line_log_ring_buffer llrb_checker u_llrb_checker (.*);
